FILE: hw/rtl/notif_attr_response_parser_top_assert.svh
// Assertion macros for the parser module.
`ifndef NOTIF_ATTR_RESPONSE_PARSER_TOP_ASSERT_SVH
`define NOTIF_ATTR_RESPONSE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NAP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NAP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NAP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NAP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/nap_pkg.sv
package nap_pkg;

  localparam logic [7:0] MSG_ATTR_ID = 8'd3;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_UID    = 3'd1,
    PH_ATTR   = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_DATA   = 3'd5
  } nap_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } nap_item_t;

  typedef struct packed {
    logic [7:0] attribute_id;
    logic [7:0] payload_byte;
    logic       byte_kept;
    logic       attribute_end;
    logic       notification_done;
  } nap_result_t;

endpackage

FILE: hw/rtl/notif_attr_response_parser_top.sv
// Each byte passes the input register, then the result register, before its result transaction.
// Throughput: one byte per cycle unless out_stall holds a result; parse state updates once per byte.
// Bytes that produce no result (command, uid, id, length) are consumed without output.
// Reset: rst is synchronous, active high; parser returns to waiting, both registers empty.
// Writing request_uid also returns the parser to waiting.
module notif_attr_response_parser_top
  import nap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        request_uid_we,
  input  logic [31:0] request_uid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  attribute_id,
  output logic [7:0]  payload_byte,
  output logic        byte_kept,
  output logic        attribute_end,
  output logic        notification_done
);

  nap_item_t   item;
  nap_result_t res;
  logic        take;

  nap_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .take      (take),
    .item      (item)
  );

  nap_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (take),
    .uid_we    (request_uid_we),
    .uid_value (request_uid),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  assign attribute_id      = res.attribute_id;
  assign payload_byte      = res.payload_byte;
  assign byte_kept         = res.byte_kept;
  assign attribute_end     = res.attribute_end;
  assign notification_done = res.notification_done;

endmodule

FILE: hw/rtl/nap_in_reg.sv
module nap_in_reg
  import nap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       take,
  output nap_item_t  item
);

  logic       hold_valid;
  logic [7:0] hold_data;
  logic       load;

  assign in_stall = hold_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_data <= data_byte;
    end
  end

  assign item.valid = hold_valid;
  assign item.data  = hold_data;

endmodule

FILE: hw/rtl/nap_parser.sv
`include "notif_attr_response_parser_top_assert.svh"

module nap_parser
  import nap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  nap_item_t   item,
  output logic        take,
  input  logic        uid_we,
  input  logic [31:0] uid_value,
  output logic        res_valid,
  input  logic        res_stall,
  output nap_result_t res
);

  nap_phase_t  phase, phase_next;
  logic [31:0] request_uid;
  logic [31:0] uid_gather, uid_gather_next;
  logic [2:0]  uid_byte_count, uid_byte_count_next;
  logic [7:0]  current_attr, current_attr_next;
  logic [15:0] record_length, record_length_next;
  logic [15:0] record_bytes_seen, record_bytes_seen_next;

  logic [2:0]  count_inc;
  logic [31:0] gather_or;
  logic [15:0] seen_inc;
  logic        last;
  logic        emit;
  nap_result_t res_next;

  assign take      = item.valid && (!res_valid || !res_stall);
  assign count_inc = uid_byte_count + 3'd1;
  assign gather_or = uid_gather | ({24'd0, item.data} << {uid_byte_count[1:0], 3'b000});
  assign seen_inc  = record_bytes_seen + 16'd1;
  assign last      = seen_inc >= record_length;

  always_comb begin
    phase_next             = phase;
    uid_gather_next        = uid_gather;
    uid_byte_count_next    = uid_byte_count;
    current_attr_next      = current_attr;
    record_length_next     = record_length;
    record_bytes_seen_next = record_bytes_seen;
    unique case (phase)
      PH_UID: begin
        uid_gather_next     = gather_or;
        uid_byte_count_next = count_inc;
        if (count_inc >= 3'd4) begin
          phase_next = (gather_or == request_uid) ? PH_ATTR : PH_WAIT;
        end
      end
      PH_ATTR: begin
        current_attr_next = item.data;
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        record_length_next = {8'd0, item.data};
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        record_length_next     = {item.data, record_length[7:0]};
        record_bytes_seen_next = 16'd0;
        phase_next = ({item.data, record_length[7:0]} == 16'd0) ? PH_ATTR : PH_DATA;
      end
      PH_DATA: begin
        record_bytes_seen_next = seen_inc;
        if (last) begin
          phase_next = PH_ATTR;
        end
      end
      default: begin
        if (item.data == 8'd0) begin
          phase_next          = PH_UID;
          uid_byte_count_next = 3'd0;
          uid_gather_next     = 32'd0;
        end else begin
          phase_next = PH_WAIT;
        end
      end
    endcase
  end

  always_comb begin
    emit                       = (phase == PH_DATA);
    res_next.attribute_id      = current_attr;
    res_next.payload_byte      = item.data;
    res_next.byte_kept         = item.data != 8'd0;
    res_next.attribute_end     = last;
    res_next.notification_done = last && (current_attr == MSG_ATTR_ID);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      request_uid    <= 32'd0;
      uid_byte_count <= 3'd0;
    end else if (uid_we) begin
      phase       <= PH_WAIT;
      request_uid <= uid_value;
    end else if (take) begin
      phase          <= phase_next;
      uid_byte_count <= uid_byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uid_gather        <= 32'd0;
      current_attr      <= 8'd0;
      record_length     <= 16'd0;
      record_bytes_seen <= 16'd0;
    end else if (take && !uid_we) begin
      uid_gather        <= uid_gather_next;
      current_attr      <= current_attr_next;
      record_length     <= record_length_next;
      record_bytes_seen <= record_bytes_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

  `NAP_ASSERT_IMP(a_done_at_end, clk, rst, res_valid && res.notification_done, res.attribute_end)
  `NAP_ASSERT_IMP(a_done_is_msg, clk, rst, res_valid && res.notification_done, res.attribute_id == MSG_ATTR_ID)
  `NAP_ASSERT_IMP(a_data_len, clk, rst, phase == PH_DATA, record_length != 16'd0)
  `NAP_ASSERT_NXT(a_cfg_wait, clk, rst, uid_we, phase == PH_WAIT)
  `NAP_ASSERT_NXT(a_data_emits, clk, rst, take && !uid_we && phase == PH_DATA, res_valid)

endmodule
